FILE: src/pfma_pkg.sv
// Package for the point frame moving average unit.
// Holds the fixed field widths, the register map and the coordinate type.
// No dependencies.
package pfma_pkg;

	localparam int COORD_BITS = 16;
	localparam int FC_BITS = 4;
	localparam int PPF_BITS = 13;
	localparam int CFG_DATA_BITS = 13;
	localparam int CFG_INDEX_BITS = 1;
	localparam int LANES_PER_GROUP = 8;

	localparam logic [FC_BITS-1:0] FRAME_COUNT_RESET = 4'd5;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_COUNT      = 1'b0,
		REG_POINTS_PER_FRAME = 1'b1
	} cfg_reg_t;

endpackage

FILE: src/pfma_if.sv
// Valid/ready channel interfaces of the point frame moving average unit.
// Depends on pfma_pkg for the coordinate type.
interface pfma_point_if;
	logic valid;
	logic ready;
	pfma_pkg::coord_t coord_x;
	pfma_pkg::coord_t coord_y;
	pfma_pkg::coord_t coord_z;

	modport source(output valid, coord_x, coord_y, coord_z, input ready);
	modport sink(input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface pfma_mean_if;
	logic valid;
	logic ready;
	pfma_pkg::coord_t mean_x;
	pfma_pkg::coord_t mean_y;
	pfma_pkg::coord_t mean_z;
	logic frame_end;

	modport source(output valid, mean_x, mean_y, mean_z, frame_end, input ready);
	modport sink(input valid, mean_x, mean_y, mean_z, frame_end, output ready);
endinterface

FILE: src/point_frame_moving_average_unit.sv
// Top level of the point frame moving average unit.
// Depends on pfma_pkg, pfma_if, pfma_front, pfma_queue, pfma_back and pfma_ram.
//
// Averages 3-D points over the last frame_count frames, point position by
// point position. After reset or a frame_count write the first frame_count
// frames are stored without output; from then on every point is stored in
// its ring slot and the truncated mean over all stored frames at its
// position comes out, flagged with frame_end on the last point of a frame.
// The frame memory is one bank per frame, so a point is written and all
// frames at its position are read in the same cycle: the unit takes one
// point per clock and gives one mean per clock while the output is ready.
// A point passes the queue and the read, sum, total, product and output
// registers. The frame memory is not cleared and needs no time after reset.
// Write the registers only while no point is in flight.
module point_frame_moving_average_unit #(
	parameter int MAX_FRAMES = 8,
	parameter int MAX_POINTS = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	pfma_point_if.sink                          pt,
	pfma_mean_if.source                         avg,
	input  logic                                cfg_we,
	input  logic [pfma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [pfma_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SLW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int NFW = $clog2(MAX_FRAMES + 1);

	typedef struct packed {
		pfma_pkg::coord_t coord_x;
		pfma_pkg::coord_t coord_y;
		pfma_pkg::coord_t coord_z;
		logic [PW-1:0]    pos;
		logic [SLW-1:0]   slot;
		logic [NFW-1:0]   nf;
		logic             last;
		logic             emit;
	} job_t;

	logic job_valid;
	logic job_ready;
	job_t job;
	logic exec_valid;
	logic exec_ready;
	job_t exec_job;

	pfma_front #(
		.MAX_FRAMES(MAX_FRAMES),
		.MAX_POINTS(MAX_POINTS),
		.job_t     (job_t)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt       (pt),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job)
	);

	pfma_queue #(
		.item_t(job_t)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (job_valid),
		.in_ready (job_ready),
		.in_item  (job),
		.out_valid(exec_valid),
		.out_ready(exec_ready),
		.out_item (exec_job)
	);

	pfma_back #(
		.MAX_FRAMES(MAX_FRAMES),
		.MAX_POINTS(MAX_POINTS),
		.job_t     (job_t)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(exec_valid),
		.job_ready(exec_ready),
		.job      (exec_job),
		.avg      (avg)
	);

`ifndef SYNTH
	a_slot_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job_ready) |->
			((NFW + SLW)'(job.slot) < (NFW + SLW)'(job.nf)))
		else $error("Queued item names a ring slot beyond the frame count.");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_index == pfma_pkg::REG_FRAME_COUNT)) |=>
			!(job_valid && job_ready &&
				((job.slot != '0) || (job.pos != '0) || job.emit)))
		else $error("Frame count write did not restart warm-up at slot zero.");

	a_slot_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job_ready && !job.last &&
			!(cfg_we && (cfg_index == pfma_pkg::REG_FRAME_COUNT))) |=>
			(!(job_valid && job_ready) ||
				((job.slot == $past(job.slot)) && (job.emit == $past(job.emit)))))
		else $error("Ring slot or warm-up state changed inside a frame.");
`endif

endmodule

FILE: src/pfma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfma_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/pfma_queue.sv
// Two-entry queue that decouples the front and back parts.
// Generic in the item type; no package dependencies.
module pfma_queue #(
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);

	localparam logic [1:0] DEPTH = 2'd2;

	item_t      entry_q [2];
	logic [1:0] count_q;
	logic       wr_q;
	logic       rd_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != DEPTH);
	assign out_valid = (count_q != 2'd0);
	assign out_item  = entry_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && pop) begin
				count_q <= count_q - 2'd1;
			end
			wr_q <= wr_q ^ push;
			rd_q <= rd_q ^ pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= in_item;
		end
	end

endmodule

FILE: src/pfma_front.sv
// Front part: accepts points, holds the configuration registers and tracks
// frame position, ring slot and warm-up. Depends on pfma_pkg and pfma_if.
module pfma_front #(
	parameter int MAX_FRAMES = 8,
	parameter int MAX_POINTS = 4096,
	parameter type job_t = logic
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	pfma_point_if.sink                            pt,
	input  logic                                  cfg_we,
	input  logic [pfma_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [pfma_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output logic                                  job_valid,
	input  logic                                  job_ready,
	output job_t                                  job
);

	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PNW = $clog2(MAX_POINTS + 1);
	localparam int SLW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int NFW = $clog2(MAX_FRAMES + 1);
	localparam int CW = NFW + SLW;
	localparam int PPF_MAX = (1 << pfma_pkg::PPF_BITS) - 1;
	localparam int PPF_RESET = (MAX_POINTS > PPF_MAX) ? PPF_MAX : MAX_POINTS;

	logic [pfma_pkg::FC_BITS-1:0]  fc_q;
	logic [pfma_pkg::PPF_BITS-1:0] ppf_q;
	logic [PW-1:0]                 pos_q;
	logic [SLW-1:0]                slot_q;
	logic                          warm_q;

	logic [NFW-1:0] nf;
	logic [PNW-1:0] np;
	logic [SLW-1:0] slot_cur;
	logic [SLW-1:0] slot_next;
	logic           last;
	logic           wrap;
	logic           accept;
	logic           fc_write;

	always_comb begin
		if (fc_q == '0) begin
			nf = NFW'(1);
		end else if (32'(fc_q) > 32'(MAX_FRAMES)) begin
			nf = NFW'(MAX_FRAMES);
		end else begin
			nf = NFW'(fc_q);
		end

		if (ppf_q == '0) begin
			np = PNW'(1);
		end else if (32'(ppf_q) > 32'(MAX_POINTS)) begin
			np = PNW'(MAX_POINTS);
		end else begin
			np = PNW'(ppf_q);
		end

		slot_cur  = (CW'(slot_q) >= CW'(nf)) ? '0 : slot_q;
		last      = ((PNW + 1)'(pos_q) + (PNW + 1)'(1)) >= (PNW + 1)'(np);
		wrap      = (CW'(slot_cur) + CW'(1)) >= CW'(nf);
		slot_next = wrap ? '0 : SLW'(slot_cur + SLW'(1));
	end

	assign accept    = pt.valid && job_ready;
	assign fc_write  = cfg_we && (cfg_index == pfma_pkg::REG_FRAME_COUNT);
	assign pt.ready  = job_ready;
	assign job_valid = pt.valid;

	always_comb begin
		job         = '0;
		job.coord_x = pt.coord_x;
		job.coord_y = pt.coord_y;
		job.coord_z = pt.coord_z;
		job.pos     = pos_q;
		job.slot    = slot_cur;
		job.nf      = nf;
		job.last    = last;
		job.emit    = warm_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= pfma_pkg::FRAME_COUNT_RESET;
			ppf_q  <= pfma_pkg::PPF_BITS'(PPF_RESET);
			pos_q  <= '0;
			slot_q <= '0;
			warm_q <= 1'b0;
		end else if (fc_write) begin
			fc_q   <= cfg_data[pfma_pkg::FC_BITS-1:0];
			pos_q  <= '0;
			slot_q <= '0;
			warm_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == pfma_pkg::REG_POINTS_PER_FRAME)) begin
				ppf_q <= cfg_data[pfma_pkg::PPF_BITS-1:0];
			end
			if (accept) begin
				pos_q <= last ? '0 : PW'(pos_q + PW'(1));
				if (last) begin
					slot_q <= slot_next;
					if (wrap) begin
						warm_q <= 1'b1;
					end
				end else begin
					slot_q <= slot_cur;
				end
			end
		end
	end

endmodule

FILE: src/pfma_back.sv
// Back part: writes each point into its frame bank, reads all banks at the
// point position, sums, divides by the frame count and drives the result.
// Depends on pfma_pkg, pfma_if and pfma_ram.
module pfma_back #(
	parameter int MAX_FRAMES = 8,
	parameter int MAX_POINTS = 4096,
	parameter type job_t = logic
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	output logic       job_ready,
	input  job_t       job,
	pfma_mean_if.source avg
);

	localparam int CB = pfma_pkg::COORD_BITS;
	localparam int LOGF = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 0;
	localparam int MB = CB + LOGF;
	localparam int SW = MB + 1;
	localparam int K = MB + LOGF;
	localparam int PRW = MB + K + 1;
	localparam int SLW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int NFW = $clog2(MAX_FRAMES + 1);
	localparam int LPG = pfma_pkg::LANES_PER_GROUP;
	localparam int GROUPS = (MAX_FRAMES + LPG - 1) / LPG;
	localparam int DW = 3 * CB;

	logic adv;
	logic pop;
	logic [DW-1:0] wdata;
	logic [DW-1:0] rd_bank [MAX_FRAMES];
	logic [K:0]    recip [MAX_FRAMES + 1];

	logic           v_s1;
	logic           emit_s1;
	logic           last_s1;
	logic [NFW-1:0] nf_s1;
	logic [SLW-1:0] slot_s1;
	logic [DW-1:0]  new_s1;

	logic signed [SW-1:0] lane [3][MAX_FRAMES];
	logic signed [SW-1:0] grp_sum [3][GROUPS];

	logic                 v_s2;
	logic                 last_s2;
	logic [NFW-1:0]       nf_s2;
	logic signed [SW-1:0] grp_s2 [3][GROUPS];

	logic signed [SW-1:0] tot [3];

	logic                 v_s3;
	logic                 last_s3;
	logic [NFW-1:0]       nf_s3;
	logic signed [SW-1:0] tot_s3 [3];

	logic [MB-1:0] mag [3];

	logic           v_s4;
	logic           last_s4;
	logic [2:0]     neg_s4;
	logic [PRW-1:0] prod_s4 [3];

	logic [MB-1:0] quo [3];

	logic                 out_valid_q;
	logic                 end_q;
	pfma_pkg::coord_t     mean_q [3];

	assign adv       = !out_valid_q || avg.ready;
	assign pop       = adv && job_valid;
	assign job_ready = adv;
	assign wdata     = {job.coord_z, job.coord_y, job.coord_x};

	for (genvar b = 0; b < MAX_FRAMES; b++) begin : g_bank
		pfma_ram #(
			.WIDTH(DW),
			.DEPTH(MAX_POINTS)
		) u_bank (
			.clk  (clk),
			.we   (pop && (job.slot == SLW'(b))),
			.waddr(job.pos),
			.wdata(wdata),
			.re   (pop),
			.raddr(job.pos),
			.rdata(rd_bank[b])
		);
	end

	// Reciprocals scaled by 2^K give the exact truncated quotient for every
	// sum magnitude that fits in MB bits.
	for (genvar d = 0; d <= MAX_FRAMES; d++) begin : g_recip
		localparam longint unsigned DEN = (d == 0) ? 1 : d;
		localparam longint unsigned RV = ((longint'(1) << K) + DEN - 1) / DEN;
		assign recip[d] = (K + 1)'(RV);
	end

	// The bank being written this item returns stale data, so the new point
	// is taken from the item itself.
	for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_lane
		for (genvar c = 0; c < 3; c++) begin : g_coord
			assign lane[c][k] = (NFW'(k) < nf_s1) ?
				SW'(signed'((slot_s1 == SLW'(k)) ? new_s1[c*CB +: CB] : rd_bank[k][c*CB +: CB])) :
				'0;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int g = 0; g < GROUPS; g++) begin
				grp_sum[c][g] = '0;
				for (int l = 0; l < LPG; l++) begin
					if (g * LPG + l < MAX_FRAMES) begin
						grp_sum[c][g] = grp_sum[c][g] + lane[c][g * LPG + l];
					end
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			tot[c] = '0;
			for (int g = 0; g < GROUPS; g++) begin
				tot[c] = tot[c] + grp_s2[c][g];
			end
			mag[c] = tot_s3[c][SW-1] ? MB'(-tot_s3[c]) : MB'(tot_s3[c]);
			quo[c] = prod_s4[c][K +: MB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= job_valid;
			v_s2        <= v_s1 && emit_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			emit_s1 <= job.emit;
			last_s1 <= job.last;
			nf_s1   <= job.nf;
			slot_s1 <= job.slot;
			new_s1  <= wdata;
		end
		if (adv) begin
			last_s2 <= last_s1;
			nf_s2   <= nf_s1;
			grp_s2  <= grp_sum;
			last_s3 <= last_s2;
			nf_s3   <= nf_s2;
			tot_s3  <= tot;
			last_s4 <= last_s3;
			for (int c = 0; c < 3; c++) begin
				neg_s4[c]  <= tot_s3[c][SW-1];
				prod_s4[c] <= PRW'(mag[c]) * PRW'(recip[nf_s3]);
			end
		end
		if (adv && v_s4) begin
			end_q <= last_s4;
			for (int c = 0; c < 3; c++) begin
				mean_q[c] <= CB'(neg_s4[c] ? MB'(-quo[c]) : quo[c]);
			end
		end
	end

	assign avg.valid     = out_valid_q;
	assign avg.mean_x    = mean_q[0];
	assign avg.mean_y    = mean_q[1];
	assign avg.mean_z    = mean_q[2];
	assign avg.frame_end = end_q;

endmodule
